/* design/sicrd_pkg.sv */
// ----------------------------------------------------------------------------
// sicrd_pkg
// Shared types and constants for the signed integer to radix digits unit.
// ----------------------------------------------------------------------------
package sicrd_pkg;

   localparam int VALUE_W     = 32;
   localparam int SYMBOL_W    = 8;
   localparam int NUM_SYMBOLS = 16;
   localparam int DIGIT_W     = 4;
   localparam int RADIX_W     = 5;
   localparam int MAX_DIGITS  = 32;
   localparam int COUNT_W     = 6;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 64;

   // Quotient bits resolved by the divider in one cycle.
   localparam int DIV_STEP_BITS = 8;
   localparam int DIV_CYCLES    = VALUE_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

   localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      REG_SYMBOLS_LOW  = 2'd0,
      REG_SYMBOLS_HIGH = 2'd1,
      REG_BASE_LENGTH  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [NUM_SYMBOLS-1:0][SYMBOL_W-1:0] symbols;
      logic [RADIX_W-1:0]                   radix;
      logic                                 valid;
   } alphabet_type;

   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] dividend;
      logic [RADIX_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quotient;
      logic [DIGIT_W-1:0] remainder;
   } div_rsp_type;

endpackage

/* design/sicrd_req_if.sv */
// ----------------------------------------------------------------------------
// sicrd_req_if
// Request channel: one signed value per request.
// ----------------------------------------------------------------------------
interface sicrd_req_if
   import sicrd_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

/* design/sicrd_rsp_if.sv */
// ----------------------------------------------------------------------------
// sicrd_rsp_if
// Result channel: one character byte per transfer, flagged on the last one.
// ----------------------------------------------------------------------------
interface sicrd_rsp_if
   import sicrd_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic                last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

/* design/sicrd_csr.sv */
// ----------------------------------------------------------------------------
// sicrd_csr
// APB register block holding the digit alphabet, with a registered check
// of whether the alphabet can be used.
// ----------------------------------------------------------------------------
module sicrd_csr
   import sicrd_pkg::*;
#(
   parameter int MAX_RADIX = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output alphabet_type          alpha
);

   logic [CSR_DATA_W-1:0]                symbols_low_ff;
   logic [CSR_DATA_W-1:0]                symbols_high_ff;
   logic [RADIX_W-1:0]                   base_length_ff;
   logic                                 valid_ff;
   logic                                 valid_in;
   logic [NUM_SYMBOLS-1:0][SYMBOL_W-1:0] sym;
   reg_index_type                        index;

   assign sym    = {symbols_high_ff, symbols_low_ff};
   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:3]);
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
         base_length_ff  <= '0;
         valid_ff        <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (psel && penable && pwrite) begin
            unique case (index)
               REG_SYMBOLS_LOW:  symbols_low_ff  <= pwdata;
               REG_SYMBOLS_HIGH: symbols_high_ff <= pwdata;
               REG_BASE_LENGTH:  base_length_ff  <= pwdata[RADIX_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (index)
         REG_SYMBOLS_LOW:  prdata = symbols_low_ff;
         REG_SYMBOLS_HIGH: prdata = symbols_high_ff;
         REG_BASE_LENGTH:  prdata = {{(CSR_DATA_W-RADIX_W){1'b0}}, base_length_ff};
         default:          prdata = '0;
      endcase
   end

   // Only the symbols below the configured length take part in the check.
   always_comb begin
      logic bad;
      bad = (base_length_ff < RADIX_W'(2)) || (base_length_ff > RADIX_W'(MAX_RADIX));
      for (int i = 0; i < MAX_RADIX; i++) begin
         if (RADIX_W'(i) < base_length_ff &&
             (sym[i] == SYM_PLUS || sym[i] == SYM_MINUS)) begin
            bad = 1'b1;
         end
         for (int j = i + 1; j < MAX_RADIX; j++) begin
            if (RADIX_W'(j) < base_length_ff && sym[i] == sym[j]) begin
               bad = 1'b1;
            end
         end
      end
      valid_in = !bad;
   end

   assign alpha.symbols = sym;
   assign alpha.radix   = base_length_ff;
   assign alpha.valid   = valid_ff;

endmodule

/* design/sicrd_div.sv */
// ----------------------------------------------------------------------------
// sicrd_div
// Iterative divider of a 32-bit magnitude by the radix, resolving several
// quotient bits per cycle by restoring long division.
// ----------------------------------------------------------------------------
module sicrd_div
   import sicrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_CNT_W-1:0] cnt_in;
   logic [VALUE_W-1:0]   shift_ff;
   logic [VALUE_W-1:0]   shift_in;
   logic [DIGIT_W-1:0]   rem_ff;
   logic [DIGIT_W-1:0]   rem_in;
   logic [RADIX_W-1:0]   divisor_ff;
   logic [VALUE_W-1:0]   step_shift;
   logic [DIGIT_W-1:0]   step_rem;

   // The dividend shifts out at the top while quotient bits enter at the bottom.
   always_comb begin
      logic [RADIX_W-1:0] trial;
      step_shift = shift_ff;
      step_rem   = rem_ff;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         trial      = {step_rem, step_shift[VALUE_W-1]};
         step_shift = {step_shift[VALUE_W-2:0], 1'b0};
         if (trial >= divisor_ff) begin
            step_rem      = DIGIT_W'(trial - divisor_ff);
            step_shift[0] = 1'b1;
         end else begin
            step_rem = trial[DIGIT_W-1:0];
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = div_req.dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = step_shift;
         rem_in   = step_rem;
         cnt_in   = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      if (div_req.start) begin
         divisor_ff <= div_req.divisor;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = shift_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

/* design/signed_int_to_custom_radix_digits_unit.sv */
// ----------------------------------------------------------------------------
// signed_int_to_custom_radix_digits_unit
// Writes a signed 32-bit value as text in a configured radix and alphabet.
// ----------------------------------------------------------------------------
// Each digit costs one pass of the single divider (8 quotient bits per step,
// plus hand-off), and a negative value adds a leading minus sign.
// The block takes one request at a time, accepting the next only when idle;
// an unusable alphabet ends the request with no result.
// Reset clears the alphabet registers to zero (alphabet unusable) and idles the block.
// ----------------------------------------------------------------------------
module signed_int_to_custom_radix_digits_unit
   import sicrd_pkg::*;
#(
   parameter int MAX_RADIX = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   sicrd_req_if.sink             req_bus,
   sicrd_rsp_if.source           rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SIGN,
      ST_DIVGO,
      ST_DIVWAIT,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [VALUE_W-1:0]   mag_ff;
   logic [COUNT_W-1:0]   ndig_ff;
   logic                 rsp_valid_ff;
   logic [SYMBOL_W-1:0]  rsp_symbol_ff;
   logic                 rsp_last_ff;
   logic [DIGIT_W-1:0]   digit_ff [MAX_DIGITS];

   alphabet_type         alpha;
   div_req_type          div_req;
   div_rsp_type          div_rsp;
   logic                 out_free;
   logic                 emit_now;
   logic [DIGIT_W:0]     rd_idx;
   logic [SYMBOL_W-1:0]  digit_sym;

   sicrd_csr #(
      .MAX_RADIX (MAX_RADIX)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .alpha   (alpha)
   );

   sicrd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign div_req.start    = (state_ff == ST_DIVGO);
   assign div_req.dividend = mag_ff;
   assign div_req.divisor  = alpha.radix;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign emit_now  = (state_ff == ST_SIGN || state_ff == ST_EMIT) && out_free;
   assign rd_idx    = ndig_ff[DIGIT_W:0] - (DIGIT_W+1)'(1);
   assign digit_sym = alpha.symbols[digit_ff[rd_idx]];

   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.symbol = rsp_symbol_ff;
   assign rsp_bus.last   = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ndig_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  value_ff <= req_bus.value;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               ndig_ff <= '0;
               mag_ff  <= value_ff[VALUE_W-1] ? (VALUE_W'(0) - value_ff) : value_ff;
               if (!alpha.valid) begin
                  state_ff <= ST_IDLE;
               end else if (value_ff[VALUE_W-1]) begin
                  state_ff <= ST_SIGN;
               end else begin
                  state_ff <= ST_DIVGO;
               end
            end
            ST_SIGN: begin
               if (out_free) begin
                  rsp_symbol_ff <= SYM_MINUS;
                  rsp_last_ff   <= 1'b0;
                  state_ff      <= ST_DIVGO;
               end
            end
            ST_DIVGO: begin
               state_ff <= ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
               if (div_rsp.done) begin
                  mag_ff  <= div_rsp.quotient;
                  ndig_ff <= ndig_ff + COUNT_W'(1);
                  if (div_rsp.quotient == '0 || ndig_ff == COUNT_W'(MAX_DIGITS - 1)) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     state_ff <= ST_DIVGO;
                  end
               end
            end
            ST_EMIT: begin
               // Digits were found least significant first, so they leave in reverse.
               if (out_free) begin
                  rsp_symbol_ff <= digit_sym;
                  rsp_last_ff   <= (ndig_ff == COUNT_W'(1));
                  ndig_ff       <= ndig_ff - COUNT_W'(1);
                  if (ndig_ff == COUNT_W'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIVWAIT && div_rsp.done) begin
         digit_ff[ndig_ff[DIGIT_W:0]] <= div_rsp.remainder;
      end
   end

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      ndig_ff <= COUNT_W'(MAX_DIGITS))
      else $error("digit count beyond the buffer depth");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIVWAIT)
      else $error("divider finished outside the wait state");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && ndig_ff == COUNT_W'(1))
      |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final digit did not close the request");

   a_sign_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && alpha.valid && value_ff[VALUE_W-1])
      |=> (state_ff == ST_SIGN && ndig_ff == '0))
      else $error("negative request skipped its sign");

endmodule
